@@ rtl/core/rmsd_pkg.sv @@
`default_nettype none

package rmsd_pkg;

   // sample and result widths are fixed by the stream format
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned MAG_W    = 17;
   localparam int unsigned SQ_W     = 31;   // 32768^2 = 2^30 fits
   localparam int unsigned LEVEL_W  = 15;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'h7FFF;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ACC  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SQRT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/rmsd_div.sv @@
`default_nettype none

// restoring divider, one quotient bit per cycle
module rmsd_div #(
   parameter int unsigned DVD_W = 51,
   parameter int unsigned DVS_W = 20
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int unsigned CNT_W = $clog2(DVD_W + 1);
   localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(DVD_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   logic [DVS_W:0]   shifted;
   logic [DVS_W:0]   diff;
   logic             ge;

   assign shifted = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_INIT;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

@@ rtl/core/rmsd_sqrt.sv @@
`default_nettype none

// digit-by-digit integer square root, two radicand bits per cycle
module rmsd_sqrt #(
   parameter int unsigned RAD_W = 52
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [RAD_W-1:0]   radicand,
   output logic                    done,
   output logic [RAD_W/2-1:0]      root
);

   localparam int unsigned RT_W  = RAD_W / 2;
   localparam int unsigned CNT_W = $clog2(RT_W + 1);
   localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(RT_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [RT_W:0]    rem_ff, rem_in;    // remainder stays <= 2*root
   logic [RT_W-1:0]  root_ff, root_in;

   logic [RT_W+2:0]  rem_sh;
   logic [RT_W+2:0]  trial;
   logic [RT_W+2:0]  diff;
   logic             ge;

   assign rem_sh = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;
   assign diff   = rem_sh - trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_INIT;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         rem_in  = ge ? diff[RT_W:0] : rem_sh[RT_W:0];
         root_in = {root_ff[RT_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ rtl/core/rms_envelope_downsampler_core.sv @@
`default_nettype none

// RMS envelope downsampler. Each accepted request carries one signed 16-bit
// sample; its square is added to a bucket sum. When the bucket holds
// samples_per_bucket or more samples (0 acts as 1), or the request has tlast
// set, the block returns floor(sqrt(floor(sum / samples_per_bucket))),
// capped at 32767, with rsp_tlast copying the request's tlast, and clears
// the bucket. A partial bucket closed by tlast is still divided by the full
// bucket size. A sample that does not close a bucket is squared as it is
// accepted, then added to the sum. A closing sample then runs a bit-serial
// restoring divider and a two-bits-per-cycle square root. One request is in
// work at a time; a finished level sits in an output register while the
// next samples are accepted. samples_per_bucket is written over the csr
// port, only while the block is idle.
module rms_envelope_downsampler_core #(
   parameter int unsigned MAX_BUCKET_BITS = 20
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // request: tdata = sample[15:0]; tlast = last
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [15:0]                req_tdata,
   input  wire logic                       req_tlast,
   // response: tdata = level[14:0], zero[15]; tlast = final_res
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [15:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   // config: samples_per_bucket
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [MAX_BUCKET_BITS-1:0] csr_data
);

   localparam int unsigned FILL_W = MAX_BUCKET_BITS;
   localparam int unsigned SUM_W  = MAX_BUCKET_BITS + rmsd_pkg::SQ_W - 1 + 1;
   localparam int unsigned RAD_W  = SUM_W + (SUM_W % 2);
   localparam int unsigned RT_W   = RAD_W / 2;

   rmsd_pkg::state_type state_ff, state_in;

   logic [FILL_W-1:0]              spb_ff, spb_in;
   logic [SUM_W-1:0]               sum_ff, sum_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic [rmsd_pkg::SQ_W-1:0]      sq_ff, sq_in;
   logic                           last_ff, last_in;

   logic [rmsd_pkg::LEVEL_W-1:0]   level_ff, level_in;
   logic                           final_ff, final_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [rmsd_pkg::MAG_W-1:0]     mag;
   logic [2*rmsd_pkg::MAG_W-1:0]   prod;
   logic [SUM_W-1:0]               sum_new;
   logic [FILL_W-1:0]              fill_new;
   logic [FILL_W-1:0]              size;
   logic                           close;

   logic                           div_start, div_done;
   logic [SUM_W-1:0]               quotient;
   logic                           sqrt_start, sqrt_done;
   logic [RT_W-1:0]                root;
   logic [rmsd_pkg::LEVEL_W-1:0]   level_sat;

   logic                           req_fire;
   logic                           rsp_fire;
   logic                           out_load;

   // magnitude of the two's complement sample, 17 bits to hold 32768
   always_comb begin
      mag = {req_tdata[15], req_tdata};
      if (req_tdata[15]) begin
         mag = ~mag + 1'b1;
      end
   end
   assign prod = mag * mag;

   assign size     = (spb_ff == '0) ? FILL_W'(1) : spb_ff;
   assign sum_new  = sum_ff + SUM_W'(sq_ff);
   assign fill_new = fill_ff + 1'b1;    // wraps at 2^MAX_BUCKET_BITS, which closes
   assign close    = last_ff || (fill_new == '0) || (fill_new >= size);

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_valid_ff && rsp_tready;
   assign out_load = (state_ff == rmsd_pkg::ST_OUT) && (!rsp_valid_ff || rsp_tready);

   // saturate the root to the level range
   assign level_sat = (|root[RT_W-1:rmsd_pkg::LEVEL_W]) ? rmsd_pkg::LEVEL_MAX
                                                        : root[rmsd_pkg::LEVEL_W-1:0];

   always_comb begin
      state_in     = state_ff;
      spb_in       = spb_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      sq_in        = sq_ff;
      last_in      = last_ff;
      level_in     = level_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;
      sqrt_start   = 1'b0;

      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         spb_in = csr_data;
      end

      unique case (state_ff)
         rmsd_pkg::ST_IDLE: begin
            if (req_fire) begin
               sq_in    = prod[rmsd_pkg::SQ_W-1:0];
               last_in  = req_tlast;
               state_in = rmsd_pkg::ST_ACC;
            end
         end
         rmsd_pkg::ST_ACC: begin
            if (close) begin
               // hand the closed bucket to the divider and start a new one
               div_start = 1'b1;
               sum_in    = '0;
               fill_in   = '0;
               state_in  = rmsd_pkg::ST_DIV;
            end else begin
               sum_in   = sum_new;
               fill_in  = fill_new;
               state_in = rmsd_pkg::ST_IDLE;
            end
         end
         rmsd_pkg::ST_DIV: begin
            if (div_done) begin
               sqrt_start = 1'b1;
               state_in   = rmsd_pkg::ST_SQRT;
            end
         end
         rmsd_pkg::ST_SQRT: begin
            if (sqrt_done) begin
               state_in = rmsd_pkg::ST_OUT;
            end
         end
         rmsd_pkg::ST_OUT: begin
            if (out_load) begin
               level_in     = level_sat;
               final_in     = last_ff;
               rsp_valid_in = 1'b1;
               state_in     = rmsd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmsd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmsd_pkg::ST_IDLE;
         spb_ff       <= FILL_W'(1);
         sum_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spb_ff       <= spb_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sq_ff    <= sq_in;
      last_ff  <= last_in;
      level_ff <= level_in;
      final_ff <= final_in;
   end

   rmsd_div #(
      .DVD_W (SUM_W),
      .DVS_W (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (size),
      .done     (div_done),
      .quotient (quotient)
   );

   rmsd_sqrt #(
      .RAD_W (RAD_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (RAD_W'(quotient)),
      .done     (sqrt_done),
      .root     (root)
   );

   assign req_tready = (state_ff == rmsd_pkg::ST_IDLE);
   assign csr_ready  = (state_ff == rmsd_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, level_ff};
   assign rsp_tlast  = final_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_rms_envelope_downsampler_core.sv @@
`timescale 1ns / 100ps

module tb_rms_envelope_downsampler_core;

   localparam int unsigned BKT_W         = 20;
   localparam int unsigned SETTLE_CYCLES = 120;   // longer than a bucket close takes
   localparam int unsigned HOLD_CYCLES   = 600;   // long receiver hold-off
   localparam int unsigned STALL_LIMIT   = 3000;  // cycles without any handshake
   localparam int unsigned RANDOM_ITEMS  = 1900;
   localparam logic [BKT_W-1:0] BKT_MAX  = '1;

   // one audio request, and one level the block owes us
   typedef struct packed {
      logic [rmsd_pkg::SAMPLE_W-1:0] smp;
      logic                          eos;
   } audio_req_type;

   typedef struct packed {
      logic [rmsd_pkg::LEVEL_W-1:0] level;
      logic                         fin;
   } level_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // sample[15:0]
   logic                 req_tlast  = 1'b0; // last
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;         // level[14:0], zero[15]
   logic                 rsp_tlast;         // final_res
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [BKT_W-1:0]     csr_data   = '0;

   rms_envelope_downsampler_core #(
      .MAX_BUCKET_BITS(BKT_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // -----------------------------------------------------------------------
   // Bucket predictor: shadow of the block's sum, fill count and bucket size.
   // Updated once per accepted request, in acceptance order.
   // -----------------------------------------------------------------------
   logic [50:0]      sq_total    = '0;
   logic [BKT_W-1:0] fill_cnt    = '0;
   logic [BKT_W-1:0] bucket_size = BKT_W'(1);   // reset value of the register

   audio_req_type pending_reqs[$];
   level_rec_type levels_due[$];

   int unsigned fail_count = 0;
   logic        hold_asked = 1'b0;

   function automatic void bucket_accumulate(input logic [rmsd_pkg::SAMPLE_W-1:0] smp,
                                             input logic eos);
      logic [rmsd_pkg::MAG_W-1:0] mag;
      longint unsigned            div_by;
      longint unsigned            mean;
      longint unsigned            root;
      longint unsigned            trial;
      level_rec_type              rec;
      // |sample| as 17 bits so that -32768 maps to 32768
      mag = smp[rmsd_pkg::SAMPLE_W-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
      sq_total = sq_total + mag * mag;
      fill_cnt = fill_cnt + 1'b1;              // wraps at BKT_W bits
      div_by   = (bucket_size == 0) ? 1 : bucket_size;
      // closes on last, on full, on wrap, or when the size was lowered below fill
      if (eos || fill_cnt == 0 || fill_cnt >= div_by) begin
         mean = sq_total / div_by;
         root = 0;
         for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= mean) root = trial;
         end
         rec.level = (root > rmsd_pkg::LEVEL_MAX) ? rmsd_pkg::LEVEL_MAX
                                                  : root[rmsd_pkg::LEVEL_W-1:0];
         rec.fin   = eos;
         levels_due.insert(levels_due.size(), rec);
         sq_total = '0;
         fill_cnt = '0;
      end
   endfunction

   // -----------------------------------------------------------------------
   // Request driver: pops pending requests, random gap 0..13 per request,
   // with occasional back-to-back bursts. Prediction runs at acceptance.
   // -----------------------------------------------------------------------
   int unsigned req_gap_left = 0;
   int unsigned req_burst    = 0;

   always @(posedge clock) begin : req_driver
      logic          nxt_valid;
      int unsigned   g;
      audio_req_type nx;
      if (reset) begin
         req_tvalid   <= 1'b0;
         req_gap_left <= 0;
      end else begin
         nxt_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            bucket_accumulate(req_tdata, req_tlast);
            nxt_valid = 1'b0;
            if (req_burst != 0) begin
               g = 0;
               req_burst <= req_burst - 1;
            end else begin
               g = $urandom_range(0, 13);
               if ($urandom_range(0, 24) == 0) req_burst <= $urandom_range(8, 40);
            end
            if (g != 0) begin
               req_gap_left <= g - 1;
            end else if (pending_reqs.size() != 0) begin
               // keep valid high straight into the next request
               nx = pending_reqs.pop_front();
               req_tdata <= nx.smp;
               req_tlast <= nx.eos;
               nxt_valid = 1'b1;
            end
         end else if (!req_tvalid) begin
            if (req_gap_left != 0) begin
               req_gap_left <= req_gap_left - 1;
            end else if (pending_reqs.size() != 0) begin
               nx = pending_reqs.pop_front();
               req_tdata <= nx.smp;
               req_tlast <= nx.eos;
               nxt_valid = 1'b1;
            end
         end
         req_tvalid <= nxt_valid;
      end
   end

   // -----------------------------------------------------------------------
   // Response monitor: checks each level against the oldest prediction and
   // throttles rsp_tready. One long hold-off on request from the sequence.
   // -----------------------------------------------------------------------
   int unsigned rsp_stall_left = 0;
   int unsigned rsp_burst      = 0;
   int unsigned hold_left      = 0;
   logic        hold_taken     = 1'b0;

   always @(posedge clock) begin : rsp_monitor
      level_rec_type want;
      logic          nxt_ready;
      int unsigned   s;
      if (reset) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= 0;
         hold_left      <= 0;
         hold_taken     <= 1'b0;
      end else begin
         nxt_ready = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (levels_due.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected level %0d tlast %0b", $time,
                           rsp_tdata, rsp_tlast);
               fail_count = fail_count + 1;
            end else begin
               want = levels_due.pop_front();
               if (rsp_tdata !== {1'b0, want.level} || rsp_tlast !== want.fin) begin
                  if (fail_count < 10)
                     $display("%0t: level exp %0d/%0b got tdata %0d tlast %0b",
                              $time, want.level, want.fin, rsp_tdata, rsp_tlast);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            nxt_ready = 1'b0;
         end else if (hold_asked && !hold_taken) begin
            // block must back up into its input while we sit on the output
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            nxt_ready  = 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            if (rsp_burst != 0) begin
               s = 0;
               rsp_burst <= rsp_burst - 1;
            end else begin
               s = $urandom_range(0, 13);
               if ($urandom_range(0, 19) == 0) rsp_burst <= $urandom_range(5, 20);
            end
            if (s == 0) begin
               nxt_ready = 1'b1;
            end else begin
               nxt_ready = 1'b0;
               rsp_stall_left <= s - 1;
            end
         end else if (!rsp_tready) begin
            if (rsp_stall_left != 0) rsp_stall_left <= rsp_stall_left - 1;
            else nxt_ready = 1'b1;
         end
         rsp_tready <= nxt_ready;
      end
   end

   // watchdog: any handshake on any channel counts as progress
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("rms_envelope_downsampler_core test failed");
            $finish;
         end
      end
   end

   // -----------------------------------------------------------------------
   // Sequence
   // -----------------------------------------------------------------------
   function automatic logic [rmsd_pkg::SAMPLE_W-1:0] pick_sample();
      logic [rmsd_pkg::SAMPLE_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = 16'h8000;
         1:       v = 16'h7FFF;
         2:       v = 16'($urandom_range(0, 200)) - 16'd100;   // near zero, both signs
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic queue_sample(input logic [rmsd_pkg::SAMPLE_W-1:0] smp,
                               input logic eos);
      audio_req_type r;
      r.smp = smp;
      r.eos = eos;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // sender pause: everything accepted and answered, then let the block settle
   task automatic drain_and_settle();
      while (pending_reqs.size() != 0 || req_tvalid || levels_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bucket_size(input logic [BKT_W-1:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      bucket_size = v;
   endtask

   initial begin : sequencer
      int unsigned      rand_items;
      int unsigned      n_streams;
      int unsigned      len;
      longint unsigned  eff;
      logic             closed;
      logic [BKT_W-1:0] sz;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // reset size of one: extremes, full-scale saturation, an end marker
      queue_sample(16'h0000, 1'b0);
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h8000, 1'b0);   // root 32768 -> capped
      queue_sample(16'hFFFF, 1'b0);
      queue_sample(16'h0001, 1'b0);
      queue_sample(16'h5555, 1'b0);
      queue_sample(16'hAAAA, 1'b1);
      drain_and_settle();

      // zero size behaves as one
      write_bucket_size('0);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'd12345, 1'b1);
      drain_and_settle();

      // size 3: full bucket, partial bucket closed by last, last on full
      write_bucket_size(BKT_W'(3));
      queue_sample(16'h7FFF, 1'b0);
      queue_sample(16'h8000, 1'b0);
      queue_sample(16'd100, 1'b0);
      queue_sample(16'd5, 1'b0);
      queue_sample(16'hFFFA, 1'b1);
      queue_sample(16'h1234, 1'b0);
      queue_sample(16'hEDCB, 1'b0);
      queue_sample(16'h8000, 1'b1);
      drain_and_settle();

      // size lowered below an open bucket's fill: closes on next sample
      write_bucket_size(BKT_W'(8));
      repeat (5) queue_sample(16'h8000, 1'b0);
      drain_and_settle();
      write_bucket_size(BKT_W'(2));
      queue_sample(16'h8000, 1'b0);
      drain_and_settle();

      // back-pressure: every request closes a bucket while the output is held
      write_bucket_size(BKT_W'(1));
      hold_asked <= 1'b1;
      repeat (40) queue_sample(pick_sample(), $urandom_range(0, 7) == 0);
      drain_and_settle();

      // widest size: only last closes a bucket
      write_bucket_size(BKT_MAX);
      repeat (10) queue_sample(16'h8000, 1'b0);
      queue_sample(16'h7FFF, 1'b1);
      drain_and_settle();

      // --- random: streams of samples ending in last, some left open ---
      rand_items = 0;
      while (rand_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       sz = '0;
            1:       sz = BKT_W'(1);
            2:       sz = BKT_W'(2);
            3:       sz = BKT_MAX;
            4:       sz = BKT_W'($urandom_range(1, BKT_MAX));
            5:       sz = BKT_W'($urandom_range(50, 300));
            default: sz = BKT_W'($urandom_range(3, 24));
         endcase
         drain_and_settle();
         write_bucket_size(sz);
         eff = (sz == 0) ? 1 : sz;
         n_streams = $urandom_range(2, 6);
         for (int k = 0; k < n_streams; k++) begin
            if (eff > 400) len = $urandom_range(1, 40);
            else len = $urandom_range(1, (3 * eff + 4 > 120) ? 120 : 3 * eff + 4);
            closed = ($urandom_range(0, 7) != 0);   // else a broken stream
            for (int i = 0; i < len; i++)
               queue_sample(pick_sample(), closed && (i == len - 1));
            rand_items = rand_items + len;
            if ($urandom_range(0, 5) == 0) drain_and_settle();
         end
      end

      drain_and_settle();
      if (levels_due.size() != 0) begin
         if (fail_count < 10)
            $display("%0d levels never returned", levels_due.size());
         fail_count = fail_count + levels_due.size();
      end
      if (fail_count == 0) begin
         $display("rms_envelope_downsampler_core test passed");
      end else begin
         $display("rms_envelope_downsampler_core test failed");
      end
      $finish;
   end

endmodule
